[design/qr_text_segment_packer_assert.svh]
// assertion macros for the qr text segment packer
`ifndef QR_TEXT_SEGMENT_PACKER_ASSERT_SVH
`define QR_TEXT_SEGMENT_PACKER_ASSERT_SVH

// same-cycle implication
`define QTSP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QTSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/qtsp_pkg.sv]
// types, constants and the alphanumeric lookup for the qr text segment packer
`timescale 1ns / 1ps
`default_nettype none

package qtsp_pkg;

    localparam int CHAR_W     = 8;
    localparam int BITS_W     = 11;
    localparam int GWIDTH_W   = 4;
    localparam int COUNT_W    = 16;
    localparam int PEND_W     = 2;
    localparam int ALNUM_W    = 6;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [BITS_W-1:0] NUM_RADIX   = 11'd10;
    localparam logic [BITS_W-1:0] ALNUM_RADIX = 11'd45;

    localparam logic [PEND_W-1:0] NUM_GROUP   = 2'd3;
    localparam logic [PEND_W-1:0] ALNUM_GROUP = 2'd2;
    localparam logic [PEND_W-1:0] BYTE_GROUP  = 2'd1;

    localparam logic [GWIDTH_W-1:0] GW_NONE   = 4'd0;
    localparam logic [GWIDTH_W-1:0] GW_NUM1   = 4'd4;
    localparam logic [GWIDTH_W-1:0] GW_NUM2   = 4'd7;
    localparam logic [GWIDTH_W-1:0] GW_NUM3   = 4'd10;
    localparam logic [GWIDTH_W-1:0] GW_ALNUM1 = 4'd6;
    localparam logic [GWIDTH_W-1:0] GW_ALNUM2 = 4'd11;
    localparam logic [GWIDTH_W-1:0] GW_BYTE   = 4'd8;

    typedef enum logic [1:0] {
        MODE_NUMERIC = 2'd0,
        MODE_ALNUM   = 2'd1,
        MODE_BYTE    = 2'd2
    } t_mode;

    typedef struct packed {
        logic [CHAR_W-1:0] value;
        logic              bad;
        logic              last;
    } t_item;

    typedef struct packed {
        logic [BITS_W-1:0]   bits;
        logic [GWIDTH_W-1:0] gwidth;
        logic                bad;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } t_result;

    typedef struct packed {
        logic               hit;
        logic [ALNUM_W-1:0] idx;
    } t_alnum;

    function automatic t_alnum alnum_lookup(input logic [CHAR_W-1:0] c);
        t_alnum            r;
        logic [CHAR_W-1:0] off;
        r   = '0;
        off = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            off   = c - 8'h30;
            r.hit = 1'b1;
            r.idx = off[ALNUM_W-1:0];
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            off   = c - 8'h37;
            r.hit = 1'b1;
            r.idx = off[ALNUM_W-1:0];
        end else begin
            r.hit = 1'b1;
            case (c)
                8'h20: r.idx = 6'd36;
                8'h24: r.idx = 6'd37;
                8'h25: r.idx = 6'd38;
                8'h2A: r.idx = 6'd39;
                8'h2B: r.idx = 6'd40;
                8'h2D: r.idx = 6'd41;
                8'h2E: r.idx = 6'd42;
                8'h2F: r.idx = 6'd43;
                8'h3A: r.idx = 6'd44;
                default: r.hit = 1'b0;
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/qtsp_ifs.sv]
// channel interfaces: character input, group output and mode write
`timescale 1ns / 1ps
`default_nettype none

interface qtsp_in_if;
    logic                         valid;
    logic                         ready;
    logic [qtsp_pkg::CHAR_W-1:0]  char_code;
    logic                         last_char;
    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface qtsp_out_if;
    logic                          valid;
    logic                          ready;
    logic [qtsp_pkg::BITS_W-1:0]   group_bits;
    logic [qtsp_pkg::GWIDTH_W-1:0] group_width;
    logic                          bad_char;
    logic [qtsp_pkg::COUNT_W-1:0]  char_count;
    logic                          last_result;
    modport source (output valid, output group_bits, output group_width, output bad_char,
                    output char_count, output last_result, input ready);
    modport sink (input valid, input group_bits, input group_width, input bad_char,
                  input char_count, input last_result, output ready);
endinterface

interface qtsp_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    modport source (output valid, output mode, input ready);
    modport sink (input valid, input mode, output ready);
endinterface

`default_nettype wire

[design/qtsp_front.sv]
// front end: accepts characters and classifies them for the current mode
`timescale 1ns / 1ps
`default_nettype none

module qtsp_front (
    qtsp_in_if.sink          i_in,
    input  qtsp_pkg::t_mode  i_mode,
    input  logic             i_full,
    output logic             o_push,
    output qtsp_pkg::t_item  o_item
);

    qtsp_pkg::t_alnum alnum;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign alnum      = qtsp_pkg::alnum_lookup(i_in.char_code);

    always_comb begin
        o_item.value = '0;
        o_item.bad   = 1'b0;
        o_item.last  = i_in.last_char;
        case (i_mode)
            qtsp_pkg::MODE_NUMERIC: begin
                if (i_in.char_code >= 8'h30 && i_in.char_code <= 8'h39) begin
                    o_item.value = i_in.char_code - 8'h30;
                end else begin
                    o_item.bad = 1'b1;
                end
            end
            qtsp_pkg::MODE_ALNUM: begin
                o_item.value = {{(qtsp_pkg::CHAR_W-qtsp_pkg::ALNUM_W){1'b0}}, alnum.idx};
                o_item.bad   = !alnum.hit;
            end
            qtsp_pkg::MODE_BYTE: begin
                o_item.value = i_in.char_code;
            end
            default: begin
                o_item.bad = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/qtsp_fifo.sv]
// short queue of classified characters between front and back end
`timescale 1ns / 1ps
`default_nettype none

module qtsp_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  qtsp_pkg::t_item  i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_avail,
    output qtsp_pkg::t_item  o_item
);

    qtsp_pkg::t_item                 r_mem [qtsp_pkg::FIFO_DEPTH];
    logic [qtsp_pkg::FIFO_AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [qtsp_pkg::FIFO_AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [qtsp_pkg::FIFO_AW:0]      r_count, n_count;

    localparam logic [qtsp_pkg::FIFO_AW-1:0] LAST_PTR = qtsp_pkg::FIFO_AW'(qtsp_pkg::FIFO_DEPTH-1);
    localparam logic [qtsp_pkg::FIFO_AW:0]   FULL_CNT = (qtsp_pkg::FIFO_AW+1)'(qtsp_pkg::FIFO_DEPTH);

    assign o_full  = (r_count == FULL_CNT);
    assign o_avail = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

[design/qtsp_back.sv]
// back end: accumulates groups, counts characters and registers the result
`timescale 1ns / 1ps
`default_nettype none

module qtsp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  qtsp_pkg::t_mode  i_mode,
    input  logic             i_avail,
    input  qtsp_pkg::t_item  i_item,
    output logic             o_pop,
    qtsp_out_if.source       o_out
);

    logic [qtsp_pkg::BITS_W-1:0]  r_acc, n_acc;
    logic [qtsp_pkg::PEND_W-1:0]  r_pend, n_pend;
    logic [qtsp_pkg::COUNT_W-1:0] r_cnt, n_cnt;
    logic                         r_err, n_err;
    qtsp_pkg::t_result            r_out, n_out;
    logic                         r_out_valid, n_out_valid;

    logic [qtsp_pkg::COUNT_W-1:0] cnt_inc;
    logic [qtsp_pkg::COUNT_W-1:0] cnt_out;
    logic [qtsp_pkg::BITS_W-1:0]  val_ext;
    logic [qtsp_pkg::BITS_W-1:0]  acc_new;
    logic [qtsp_pkg::PEND_W-1:0]  pend_new;
    logic [qtsp_pkg::PEND_W-1:0]  group_size;
    logic [qtsp_pkg::GWIDTH_W-1:0] gwidth;

    assign o_pop    = i_avail && (!r_out_valid || o_out.ready);
    assign cnt_inc  = (r_cnt == qtsp_pkg::COUNT_MAX) ? r_cnt : r_cnt + 1'b1;
    assign cnt_out  = i_item.last ? cnt_inc : '0;
    assign val_ext  = {{(qtsp_pkg::BITS_W-qtsp_pkg::CHAR_W){1'b0}}, i_item.value};
    assign pend_new = r_pend + 1'b1;

    // per-mode group step
    always_comb begin
        acc_new    = val_ext;
        group_size = qtsp_pkg::BYTE_GROUP;
        gwidth     = qtsp_pkg::GW_BYTE;
        case (i_mode)
            qtsp_pkg::MODE_NUMERIC: begin
                acc_new    = r_acc * qtsp_pkg::NUM_RADIX + val_ext;
                group_size = qtsp_pkg::NUM_GROUP;
                case (pend_new)
                    2'd1:    gwidth = qtsp_pkg::GW_NUM1;
                    2'd2:    gwidth = qtsp_pkg::GW_NUM2;
                    2'd3:    gwidth = qtsp_pkg::GW_NUM3;
                    default: gwidth = qtsp_pkg::GW_NONE;
                endcase
            end
            qtsp_pkg::MODE_ALNUM: begin
                acc_new    = r_acc * qtsp_pkg::ALNUM_RADIX + val_ext;
                group_size = qtsp_pkg::ALNUM_GROUP;
                gwidth     = (pend_new == qtsp_pkg::ALNUM_GROUP) ? qtsp_pkg::GW_ALNUM2
                                                                 : qtsp_pkg::GW_ALNUM1;
            end
            default: begin
                acc_new    = val_ext;
                group_size = qtsp_pkg::BYTE_GROUP;
                gwidth     = qtsp_pkg::GW_BYTE;
            end
        endcase
    end

    always_comb begin
        n_acc       = r_acc;
        n_pend      = r_pend;
        n_cnt       = r_cnt;
        n_err       = r_err;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        if (i_clear) begin
            n_acc  = '0;
            n_pend = '0;
            n_cnt  = '0;
            n_err  = 1'b0;
        end else if (o_pop) begin
            n_cnt = cnt_inc;
            if (r_err || i_item.bad) begin
                // error result, rest of segment dropped
                if (!r_err || i_item.last) begin
                    n_out.bits   = '0;
                    n_out.gwidth = qtsp_pkg::GW_NONE;
                    n_out.bad    = 1'b1;
                    n_out.count  = cnt_out;
                    n_out.last   = i_item.last;
                    n_out_valid  = 1'b1;
                end
                n_acc  = '0;
                n_pend = '0;
                n_err  = 1'b1;
            end else if (pend_new >= group_size || i_item.last) begin
                n_out.bits   = acc_new;
                n_out.gwidth = gwidth;
                n_out.bad    = 1'b0;
                n_out.count  = cnt_out;
                n_out.last   = i_item.last;
                n_out_valid  = 1'b1;
                n_acc        = '0;
                n_pend       = '0;
            end else begin
                n_acc  = acc_new;
                n_pend = pend_new;
            end
            if (i_item.last) begin
                n_acc  = '0;
                n_pend = '0;
                n_cnt  = '0;
                n_err  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_pend      <= '0;
            r_cnt       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.group_bits  = r_out.bits;
    assign o_out.group_width = r_out.gwidth;
    assign o_out.bad_char    = r_out.bad;
    assign o_out.char_count  = r_out.count;
    assign o_out.last_result = r_out.last;

endmodule

`default_nettype wire

[design/qr_text_segment_packer.sv]
// top level of the qr text segment packer
// Packs a stream of characters into QR data-segment bit groups, one character per
// transaction, with last_char on the final one. Mode (0 numeric, 1 alphanumeric,
// 2 byte) is written over the config channel; the user must write it only while
// the block is idle, which the block does not enforce. A write also clears the
// segment state. One character is taken every cycle while the queue is not full;
// the rate is set by the front end's charset lookup and the back end's combinational
// multiply-add. A result is registered when the back end pops its character from
// the queue; input stays open while a result waits, until the two-entry queue fills.
`timescale 1ns / 1ps
`default_nettype none

`include "qr_text_segment_packer_assert.svh"

module qr_text_segment_packer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qtsp_cfg_if.sink    i_cfg,
    qtsp_in_if.sink     i_in,
    qtsp_out_if.source  o_out
);

    qtsp_pkg::t_mode r_mode;
    logic            cfg_wr;
    logic            fifo_full;
    logic            fifo_push;
    logic            fifo_pop;
    logic            fifo_avail;
    qtsp_pkg::t_item front_item;
    qtsp_pkg::t_item head_item;

    logic            res_bad;
    logic            gw_empty;
    logic            res_mid;
    logic            res_num;
    logic            gw_num;
    logic            in_fire;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= qtsp_pkg::MODE_NUMERIC;
        end else if (cfg_wr) begin
            r_mode <= qtsp_pkg::t_mode'(i_cfg.mode);
        end
    end

    qtsp_front u_front (
        .i_in   (i_in),
        .i_mode (r_mode),
        .i_full (fifo_full),
        .o_push (fifo_push),
        .o_item (front_item)
    );

    qtsp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_item  (front_item),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_avail (fifo_avail),
        .o_item  (head_item)
    );

    qtsp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (cfg_wr),
        .i_mode  (r_mode),
        .i_avail (fifo_avail),
        .i_item  (head_item),
        .o_pop   (fifo_pop),
        .o_out   (o_out)
    );

    assign res_bad  = o_out.valid && o_out.bad_char;
    assign gw_empty = (o_out.group_width == qtsp_pkg::GW_NONE) && (o_out.group_bits == '0);
    assign res_mid  = o_out.valid && !o_out.last_result;
    assign res_num  = o_out.valid && !o_out.bad_char && (r_mode == qtsp_pkg::MODE_NUMERIC);
    assign gw_num   = (o_out.group_width == qtsp_pkg::GW_NUM1) ||
                      (o_out.group_width == qtsp_pkg::GW_NUM2) ||
                      (o_out.group_width == qtsp_pkg::GW_NUM3);
    assign in_fire  = i_in.valid && i_in.ready;

    `QTSP_ASSERT_IMP(a_bad_is_empty, i_clk, i_rst_n, res_bad, gw_empty, "bad result carries bits")
    `QTSP_ASSERT_IMP(a_count_on_last, i_clk, i_rst_n, res_mid, o_out.char_count == '0, "early count")
    `QTSP_ASSERT_IMP(a_num_width, i_clk, i_rst_n, res_num, gw_num, "bad numeric group width")
    `QTSP_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, in_fire, fifo_avail, "transaction not queued")

endmodule

`default_nettype wire
